/* hw/rtl/tmc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the text-mode console engine.
// Used by tmc_front, tmc_queue, tmc_back and the top level; depends on nothing.
package tmc_pkg;

	// Command codes on the input channel
	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Character codes with special meaning
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	// Attribute used after reset
	localparam logic [7:0] RESET_COLOR = 8'h07;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Classified operation handed to the back end
	typedef enum logic [2:0] {
		OP_CHAR,
		OP_NEWLINE,
		OP_BKSP,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  ch;
		logic [10:0] cidx;
	} item_t;

	// Status from back end to front end
	typedef struct packed {
		logic init_busy;
	} back_stat_t;

endpackage

/* hw/rtl/text_mode_console_engine_core.sv */
`timescale 1ns / 1ps
// Text-mode console engine: terminal screen with cursor, put/read/clear requests.
// Top level; instantiates tmc_front, tmc_queue and tmc_back, uses tmc_pkg.
//
// Input channel: in_valid/in_stall with cmd, char_code, cell_index; a request
// is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with cursor_pos, cell_data, scrolled;
// exactly one result per request, in request order.
// Text color: written through cfg_wr_en/cfg_wr_data, reset value 7.
// For a plain put, newline or backspace without scroll, the request passes
// the front stage, a queue slot and execute, then the result register loads;
// a read also passes the registered memory read. A scroll adds a copy of
// ROWS-1 rows up by one through the single memory write port, a flush step
// for the last copy write and a pass that blanks the bottom row; a clear
// adds a whole-screen fill. The back end handles one request at a time; the
// front end and a two-entry queue keep taking requests while it works.
// Reset: the screen is blanked in color 7 by a pass over all ROWS*COLUMNS
// cells; in_stall is high throughout it.
// A stalled output holds its result; the queue then fills and in_stall rises.
module text_mode_console_engine_core #(
	parameter int ROWS    = 25,
	parameter int COLUMNS = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  char_code,
	input  logic [10:0] cell_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] cursor_pos,
	output logic [15:0] cell_data,
	output logic        scrolled
);
	tmc_pkg::back_stat_t stat;
	logic                push;
	tmc_pkg::item_t      push_item;
	logic                q_full;
	logic                q_valid;
	tmc_pkg::item_t      q_item;
	logic                q_pop;

	tmc_front #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.char_code  (char_code),
		.cell_index (cell_index),
		.stat       (stat),
		.push       (push),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	tmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_item  (q_item),
		.pop       (q_pop)
	);

	tmc_back #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cursor_pos  (cursor_pos),
		.cell_data   (cell_data),
		.scrolled    (scrolled)
	);

endmodule

/* hw/rtl/tmc_front.sv */
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them into operations, feeds the queue.
// Depends on tmc_pkg.
module tmc_front #(
	parameter int ROWS    = 25,
	parameter int COLUMNS = 80
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [7:0]          char_code,
	input  logic [10:0]         cell_index,
	input  tmc_pkg::back_stat_t stat,
	output logic                push,
	output tmc_pkg::item_t      push_item,
	input  logic                q_full
);
	localparam int CELLS = ROWS * COLUMNS;

	logic           valid_s1;
	tmc_pkg::item_t item_s1;
	tmc_pkg::item_t item_cl;
	logic           accept;

	// classify the incoming request
	always_comb begin
		item_cl.ch   = char_code;
		item_cl.cidx = cell_index;
		case (cmd)
			tmc_pkg::CMD_PUT: begin
				if (char_code == tmc_pkg::CH_NEWLINE) begin
					item_cl.op = tmc_pkg::OP_NEWLINE;
				end else if (char_code == tmc_pkg::CH_BACKSPACE) begin
					item_cl.op = tmc_pkg::OP_BKSP;
				end else begin
					item_cl.op = tmc_pkg::OP_CHAR;
				end
			end
			tmc_pkg::CMD_READ: begin
				// out-of-range read leaves everything alone and returns zero
				if (32'(cell_index) < 32'(CELLS)) begin
					item_cl.op = tmc_pkg::OP_READ;
				end else begin
					item_cl.op = tmc_pkg::OP_NOP;
				end
			end
			tmc_pkg::CMD_CLEAR: item_cl.op = tmc_pkg::OP_CLEAR;
			default:            item_cl.op = tmc_pkg::OP_NOP;
		endcase
	end

	// one holding stage ahead of the queue
	assign push      = valid_s1 && !q_full;
	assign in_stall  = stat.init_busy || (valid_s1 && q_full);
	assign accept    = in_valid && !in_stall;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_cl;
		end
	end

endmodule

/* hw/rtl/tmc_queue.sv */
`timescale 1ns / 1ps
// Short request queue that decouples front end and back end.
// Depends on tmc_pkg.
module tmc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tmc_pkg::item_t push_item,
	output logic           full,
	output logic           pop_valid,
	output tmc_pkg::item_t pop_item,
	input  logic           pop
);
	tmc_pkg::item_t                 slot_q [tmc_pkg::QUEUE_DEPTH];
	logic [tmc_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [tmc_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [tmc_pkg::QUEUE_CW-1:0]   count_q;
	logic                           do_pop;

	assign full      = (count_q == tmc_pkg::QUEUE_CW'(tmc_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = slot_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == tmc_pkg::QUEUE_AW'(tmc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : tmc_pkg::QUEUE_AW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == tmc_pkg::QUEUE_AW'(tmc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : tmc_pkg::QUEUE_AW'(rd_ptr_q + 1'b1);
			end
			if ((push && !full) && !do_pop) begin
				count_q <= tmc_pkg::QUEUE_CW'(count_q + 1'b1);
			end else if (!(push && !full) && do_pop) begin
				count_q <= tmc_pkg::QUEUE_CW'(count_q - 1'b1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// fill level never exceeds the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tmc_pkg::QUEUE_CW'(tmc_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

/* hw/rtl/tmc_back.sv */
`timescale 1ns / 1ps
// Back end: screen memory, cursor, sequencer for scroll and clear sweeps,
// and the result register. Depends on tmc_pkg.
module tmc_back #(
	parameter int ROWS    = 25,
	parameter int COLUMNS = 80
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	input  logic                q_valid,
	input  tmc_pkg::item_t      q_item,
	output logic                q_pop,
	output tmc_pkg::back_stat_t stat,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [10:0]         cursor_pos,
	output logic [15:0]         cell_data,
	output logic                scrolled
);
	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int PW    = (AW > 11) ? AW : 11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FLUSH,
		ST_BLANK_ROW,
		ST_FILL,
		ST_DONE
	} state_t;

	state_t        state_q;
	logic          init_q;
	logic [AW-1:0] sweep_q;
	logic [7:0]    fill_q;
	logic [7:0]    color_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] pos_q;
	logic          copy_v_q;
	logic [AW-1:0] copy_addr_q;
	logic [15:0]   res_data_q;
	logic          res_scr_q;
	logic          out_valid_q;
	logic [10:0]   out_pos_q;
	logic [15:0]   out_data_q;
	logic          out_scr_q;

	logic [15:0]   mem [CELLS];
	logic [15:0]   mem_rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [15:0]   mem_wd;
	logic [AW-1:0] mem_ra;

	logic          last_row;
	logic          last_col;
	logic          sweep_end;
	logic [AW-1:0] bk_pos;
	logic          out_free;
	logic [PW-1:0] pos_ext;
	logic          scroll_req;

	assign last_row  = (row_q == RW'(ROWS - 1));
	assign last_col  = (col_q == CW'(COLUMNS - 1));
	assign sweep_end = (sweep_q == AW'(CELLS - 1));
	assign bk_pos    = (pos_q != '0) ? AW'(pos_q - 1'b1) : '0;
	assign out_free  = !out_valid_q || !out_stall;
	assign pos_ext   = PW'(pos_q);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	// the request at the queue head scrolls: newline or wrap on the bottom row
	assign scroll_req = last_row && (((q_item.op == tmc_pkg::OP_CHAR) && last_col)
		|| (q_item.op == tmc_pkg::OP_NEWLINE));

	assign stat.init_busy = init_q;

	assign out_valid  = out_valid_q;
	assign cursor_pos = out_pos_q;
	assign cell_data  = out_data_q;
	assign scrolled   = out_scr_q;

	// memory write port select and read address
	always_comb begin
		mem_we = 1'b0;
		mem_wa = sweep_q;
		mem_wd = {color_q, tmc_pkg::CH_SPACE};
		mem_ra = sweep_q;
		if (copy_v_q) begin
			mem_we = 1'b1;
			mem_wa = copy_addr_q;
			mem_wd = mem_rd_q;
		end else if (state_q == ST_FILL) begin
			mem_we = 1'b1;
			mem_wd = {fill_q, tmc_pkg::CH_SPACE};
		end else if (state_q == ST_BLANK_ROW) begin
			mem_we = 1'b1;
		end else if (q_pop) begin
			mem_ra = AW'(q_item.cidx);
			case (q_item.op)
				tmc_pkg::OP_CHAR: begin
					mem_we = 1'b1;
					mem_wa = pos_q;
					mem_wd = {color_q, q_item.ch};
				end
				tmc_pkg::OP_BKSP: begin
					mem_we = 1'b1;
					mem_wa = bk_pos;
				end
				default: ;
			endcase
		end
	end

	// screen memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[mem_ra];
	end

	// text color register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tmc_pkg::RESET_COLOR;
		end else if (cfg_wr_en) begin
			color_q <= cfg_wr_data;
		end
	end

	// sequencer, cursor and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			init_q      <= 1'b1;
			sweep_q     <= '0;
			fill_q      <= tmc_pkg::RESET_COLOR;
			row_q       <= '0;
			col_q       <= '0;
			pos_q       <= '0;
			copy_v_q    <= 1'b0;
			copy_addr_q <= '0;
			res_data_q  <= '0;
			res_scr_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_pos_q   <= '0;
			out_data_q  <= '0;
			out_scr_q   <= 1'b0;
		end else begin
			copy_v_q    <= (state_q == ST_SCROLL);
			copy_addr_q <= AW'(sweep_q - AW'(COLUMNS));
			// result register loads a finished request, drops once taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
				out_pos_q   <= pos_ext[10:0];
				out_data_q  <= res_data_q;
				out_scr_q   <= res_scr_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						res_data_q <= '0;
						res_scr_q  <= scroll_req;
						case (q_item.op)
							tmc_pkg::OP_CHAR: begin
								if (last_col) begin
									col_q <= '0;
									if (last_row) begin
										pos_q   <= AW'(pos_q + 1'b1 - AW'(COLUMNS));
										sweep_q <= AW'(COLUMNS);
									end else begin
										row_q <= RW'(row_q + 1'b1);
										pos_q <= AW'(pos_q + 1'b1);
									end
								end else begin
									col_q <= CW'(col_q + 1'b1);
									pos_q <= AW'(pos_q + 1'b1);
								end
							end
							tmc_pkg::OP_NEWLINE: begin
								col_q <= '0;
								if (last_row) begin
									pos_q   <= AW'(pos_q - AW'(col_q));
									sweep_q <= AW'(COLUMNS);
								end else begin
									row_q <= RW'(row_q + 1'b1);
									pos_q <= AW'(pos_q - AW'(col_q) + AW'(COLUMNS));
								end
							end
							tmc_pkg::OP_BKSP: begin
								if (col_q != '0) begin
									col_q <= CW'(col_q - 1'b1);
								end else if (row_q != '0) begin
									row_q <= RW'(row_q - 1'b1);
									col_q <= CW'(COLUMNS - 1);
								end
								pos_q <= bk_pos;
							end
							tmc_pkg::OP_CLEAR: begin
								row_q   <= '0;
								col_q   <= '0;
								pos_q   <= '0;
								fill_q  <= color_q;
								sweep_q <= '0;
							end
							default: ;
						endcase
						// next step for this request
						if (scroll_req) begin
							state_q <= ST_SCROLL;
						end else if (q_item.op == tmc_pkg::OP_READ) begin
							state_q <= ST_READ;
						end else if (q_item.op == tmc_pkg::OP_CLEAR) begin
							state_q <= ST_FILL;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					res_data_q <= mem_rd_q;
					state_q    <= ST_DONE;
				end
				// copy each row up by one, source runs ahead of destination
				ST_SCROLL: begin
					if (sweep_end) begin
						state_q <= ST_FLUSH;
					end else begin
						sweep_q <= AW'(sweep_q + 1'b1);
					end
				end
				// last copy write lands here
				ST_FLUSH: begin
					sweep_q <= AW'(CELLS - COLUMNS);
					state_q <= ST_BLANK_ROW;
				end
				ST_BLANK_ROW: begin
					if (sweep_end) begin
						state_q <= ST_DONE;
					end else begin
						sweep_q <= AW'(sweep_q + 1'b1);
					end
				end
				// whole-screen blank, after reset and for clear
				ST_FILL: begin
					if (sweep_end) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_DONE;
					end else begin
						sweep_q <= AW'(sweep_q + 1'b1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// linear position tracks row and column
	a_pos_match: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) == 32'(row_q) * 32'(COLUMNS) + 32'(col_q))
		else $error("cursor position out of step with row and column");

	// cursor column stays on screen
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= CW'(COLUMNS - 1))
		else $error("cursor column out of range");

	// copy writes only follow a scroll read
	a_copy_src: assert property (@(posedge clk) disable iff (!arst_n)
		copy_v_q |-> $past(state_q) == ST_SCROLL)
		else $error("copy write without scroll read");

	// no request is taken from the queue during the reset fill
	a_no_pop_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !q_pop)
		else $error("request popped during reset fill");

endmodule
